@@ rtl/orbb_pkg.sv @@
// ----------------------------------------------------------------------------
// orbb_pkg
// Shared types and constants for the overwriting byte ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package orbb_pkg;

  localparam int DEPTH     = 4096;
  localparam int MAX_BURST = 64;

  localparam int ADDR_W = $clog2(DEPTH);      // pointer width
  localparam int CAP_W  = 13;                 // capacity and fill count width
  localparam int LEN_W  = 7;                  // burst length width
  localparam int BYTE_W = 8;

  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(DEPTH);
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;
  localparam logic [LEN_W-1:0] BURST_MAX = LEN_W'(MAX_BURST);

  // op codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  read_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic [LEN_W-1:0]  granted_length;
    logic [CAP_W-1:0]  fill_after;
  } out_item_t;

  // result fields that travel alongside a memory read
  typedef struct packed {
    logic             zero;            // no byte granted, force out_byte to zero
    logic             last;
    logic [LEN_W-1:0] granted_length;
    logic [CAP_W-1:0] fill_after;
  } rd_meta_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage : orbb_pkg

`default_nettype wire

@@ rtl/orbb_ram.sv @@
// ----------------------------------------------------------------------------
// orbb_ram
// Simple dual-port synchronous RAM, one write port, one read port,
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module orbb_ram #(
  parameter int DATA_W = 8,
  parameter int WORDS  = 4096,
  parameter int ADDR_W = $clog2(WORDS)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : orbb_ram

`default_nettype wire

@@ rtl/overwrite_ring_byte_buffer.sv @@
// ----------------------------------------------------------------------------
// overwrite_ring_byte_buffer
// Byte ring buffer that overwrites its oldest byte when full, with burst reads.
// ----------------------------------------------------------------------------
// A write item stores one byte, so writes can stream one per clock while the
// block is idle. A read item grants min(read_length, 64, fill) bytes, which
// leave oldest first, one result per cycle from the byte memory while there is
// room downstream, the final one marked last; an empty buffer or a zero request
// gives a single result with a granted length of zero. A read occupies the
// block until its last byte is fetched (the single read port of the byte memory
// paces the burst), longer while the output is stalled.
// The output side has a result register and a skid register, so a read in
// flight when the output stalls still lands. Writing capacity empties the
// buffer (pointers and fill count to zero, stored bytes kept); a capacity of
// zero acts as one and anything above 4096 acts as 4096. cfg_ready is high
// only while the block is idle with no result waiting, and an input item is
// held off while a capacity write is offered.
// ----------------------------------------------------------------------------
`default_nettype none

module overwrite_ring_byte_buffer
  import orbb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input items
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire in_item_t         in_data,
  // results
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      out_item_t        out_data,
  // capacity register
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_data
);

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [CAP_W-1:0]  cap_r, cap_nxt;          // effective capacity, 1..DEPTH
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CAP_W-1:0]  fill_r, fill_nxt;
  logic [LEN_W-1:0]  remain_r, remain_nxt;    // bytes of the burst still to fetch
  logic [LEN_W-1:0]  grant_r, grant_nxt;
  logic [CAP_W-1:0]  fill_after_r, fill_after_nxt;

  // memory read in flight
  logic              pend_valid_r, pend_valid_nxt;
  rd_meta_t          pend_meta_r, pend_meta_nxt;

  // output register and skid register
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  out_item_t         skid_r, skid_nxt;

  // memory port signals
  logic              ram_we;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_rdata;

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  logic              in_xfer;
  logic              cfg_xfer;
  logic              take;                    // result transfer this cycle
  logic [1:0]        occ;
  logic [1:0]        occ_net;
  logic              issue_ok;                // room for one more result
  logic [LEN_W-1:0]  req_len;                 // request saturated to the burst limit
  logic [LEN_W-1:0]  n_grant;
  logic [CAP_W-1:0]  cap_cfg;
  logic [CAP_W-1:0]  wr_ptr_inc;
  logic [CAP_W-1:0]  rd_ptr_inc;
  logic [ADDR_W-1:0] wr_ptr_adv;
  logic [ADDR_W-1:0] rd_ptr_adv;
  out_item_t         land;                    // result formed from the memory read

  assign take     = out_valid_r & ~out_stall;
  assign occ      = {1'b0, out_valid_r} + {1'b0, skid_valid_r} + {1'b0, pend_valid_r};
  assign occ_net  = occ - {1'b0, take};
  assign issue_ok = (occ_net <= 2'd1);

  // a write never needs result room; a read request does (zero grant result)
  // an offered capacity write goes first
  assign in_stall = (state_r != ST_IDLE) || cfg_valid ||
                    ((in_data.op == OP_READ) && !issue_ok);
  assign in_xfer  = in_valid & ~in_stall;

  // capacity only changes once every result has left
  assign cfg_ready = (state_r == ST_IDLE) && !out_valid_r && !skid_valid_r && !pend_valid_r;
  assign cfg_xfer  = cfg_valid & cfg_ready;

  // clamp the capacity on the way in
  always_comb begin
    if (cfg_data == '0) begin
      cap_cfg = CAP_W'(1);
    end else if (cfg_data > CAP_MAX) begin
      cap_cfg = CAP_MAX;
    end else begin
      cap_cfg = cfg_data;
    end
  end

  // pointers wrap at the effective capacity
  assign wr_ptr_inc = {1'b0, wr_ptr_r} + CAP_W'(1);
  assign rd_ptr_inc = {1'b0, rd_ptr_r} + CAP_W'(1);
  assign wr_ptr_adv = (wr_ptr_inc >= cap_r) ? '0 : wr_ptr_inc[ADDR_W-1:0];
  assign rd_ptr_adv = (rd_ptr_inc >= cap_r) ? '0 : rd_ptr_inc[ADDR_W-1:0];

  // grant length: saturate, then clamp to fill level
  assign req_len = (in_data.read_length > BURST_MAX) ? BURST_MAX : in_data.read_length;
  assign n_grant = ({{(CAP_W-LEN_W){1'b0}}, req_len} > fill_r) ? fill_r[LEN_W-1:0]
                                                                 : req_len;

  // memory data joins its side fields on arrival
  always_comb begin
    land.out_byte       = pend_meta_r.zero ? '0 : ram_rdata;
    land.last           = pend_meta_r.last;
    land.granted_length = pend_meta_r.granted_length;
    land.fill_after     = pend_meta_r.fill_after;
  end

  // --------------------------------------------------------------------------
  // byte memory
  // --------------------------------------------------------------------------
  orbb_ram #(
    .DATA_W (BYTE_W),
    .WORDS  (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_ptr_r),
    .wr_data (in_data.data_byte),
    .rd_en   (ram_re),
    .rd_addr (rd_ptr_r),
    .rd_data (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // control: next state and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    cap_nxt        = cap_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    fill_nxt       = fill_r;
    remain_nxt     = remain_r;
    grant_nxt      = grant_r;
    fill_after_nxt = fill_after_r;
    pend_valid_nxt = 1'b0;
    pend_meta_nxt  = pend_meta_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cfg_xfer) begin
          // new capacity empties the buffer
          cap_nxt    = cap_cfg;
          rd_ptr_nxt = '0;
          wr_ptr_nxt = '0;
          fill_nxt   = '0;
        end else if (in_xfer && (in_data.op == OP_WRITE)) begin
          ram_we     = 1'b1;
          wr_ptr_nxt = wr_ptr_adv;
          if (fill_r >= cap_r) begin
            // full: drop the oldest byte
            rd_ptr_nxt = rd_ptr_adv;
          end else begin
            fill_nxt = fill_r + CAP_W'(1);
          end
        end else if (in_xfer) begin
          if (n_grant == '0) begin
            // nothing granted: a single empty result
            pend_valid_nxt               = 1'b1;
            pend_meta_nxt.zero           = 1'b1;
            pend_meta_nxt.last           = 1'b1;
            pend_meta_nxt.granted_length = '0;
            pend_meta_nxt.fill_after     = fill_r;
          end else begin
            fill_nxt       = fill_r - {{(CAP_W-LEN_W){1'b0}}, n_grant};
            fill_after_nxt = fill_r - {{(CAP_W-LEN_W){1'b0}}, n_grant};
            grant_nxt      = n_grant;
            remain_nxt     = n_grant;
            state_nxt      = ST_READ;
          end
        end
      end

      ST_READ: begin
        // one byte fetched per cycle while there is room downstream
        if (issue_ok) begin
          ram_re                       = 1'b1;
          rd_ptr_nxt                   = rd_ptr_adv;
          remain_nxt                   = remain_r - LEN_W'(1);
          pend_valid_nxt               = 1'b1;
          pend_meta_nxt.zero           = 1'b0;
          pend_meta_nxt.last           = (remain_r == LEN_W'(1));
          pend_meta_nxt.granted_length = grant_r;
          pend_meta_nxt.fill_after     = fill_after_r;
          if (remain_r == LEN_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // output register and skid register: skid drains first to keep order
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;

    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = pend_valid_r;
        skid_nxt       = land;
      end else if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = land;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (pend_valid_r) begin
      // output held: park the arriving result
      skid_valid_nxt = 1'b1;
      skid_nxt       = land;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cap_r        <= CAP_RESET;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      fill_r       <= '0;
      remain_r     <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cap_r        <= cap_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      fill_r       <= fill_nxt;
      remain_r     <= remain_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    grant_r      <= grant_nxt;
    fill_after_r <= fill_after_nxt;
    pend_meta_r  <= pend_meta_nxt;
    out_r        <= out_nxt;
    skid_r       <= skid_nxt;
  end

endmodule : overwrite_ring_byte_buffer

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the overwriting byte ring buffer. A plan of byte
// writes, burst reads, capacity writes and drain pauses is built up front and
// played by a clocked driver. A shadow copy of the ring predicts every read
// result, and a clocked monitor compares each result transfer, field by field,
// against the oldest prediction. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import orbb_pkg::*;

  localparam int SETTLE_CYCLES = 4;    // quiet cycles before a capacity write
  localparam int TAIL_ITEMS    = 30;   // plan entries played with no idling
  localparam int END_CYCLES    = 40;   // watch for stray results at the end
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 166;  // item count the random phases fill up to

  // kinds of plan entries
  typedef enum logic [1:0] {
    ACT_ITEM,
    ACT_CAPACITY,
    ACT_DRAIN
  } act_kind_t;

  typedef struct {
    act_kind_t        kind;
    in_item_t         item;
    logic [CAP_W-1:0] cap;
  } plan_entry_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  overwrite_ring_byte_buffer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // stimulus plan and expected read results
  plan_entry_t op_plan_q[$];
  out_item_t   expected_bytes_q[$];

  // shadow copy of the ring
  logic [BYTE_W-1:0] mem_copy [DEPTH];
  logic [ADDR_W-1:0] head_ptr;
  logic [ADDR_W-1:0] tail_ptr;
  logic [CAP_W-1:0]  held_cnt;
  logic [CAP_W-1:0]  cap_setting;

  // bookkeeping
  int unsigned due_cnt;        // results predicted, driver side only
  int unsigned got_cnt;        // results seen, updated by nonblocking writes
  int unsigned item_cnt;
  int unsigned cap_cnt;
  int unsigned err_cnt = 0;
  logic        calm = 1'b0;    // tail of the run, no idling on either side

  // plan-time fill tracking, used only to shape read lengths
  int plan_fill;
  int plan_slots;
  int plan_count;

  // clock and reset
  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // zero acts as one slot, anything past the store acts as the whole store
  function automatic int slots_for(logic [CAP_W-1:0] c);
    if (c == '0) return 1;
    if (c > CAP_MAX) return DEPTH;
    return int'(c);
  endfunction

  function automatic logic [ADDR_W-1:0] next_slot(logic [ADDR_W-1:0] p, int slots);
    int n;
    n = int'(p) + 1;
    return (n >= slots) ? '0 : ADDR_W'(n);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 15;
      2: return 40;
      default: return 70;
    endcase
  endfunction

  // predict the effect of one accepted item on the ring
  task automatic model_buffer_op(in_item_t it);
    int        slots;
    int        n;
    out_item_t r;
    slots = slots_for(cap_setting);
    if (it.op == OP_WRITE) begin
      mem_copy[tail_ptr] = it.data_byte;
      tail_ptr = next_slot(tail_ptr, slots);
      // full: oldest byte is dropped, fill stays put
      if (int'(held_cnt) >= slots) head_ptr = next_slot(head_ptr, slots);
      else held_cnt = held_cnt + 1'b1;
    end else begin
      n = int'(it.read_length);
      if (n > MAX_BURST) n = MAX_BURST;
      if (n > int'(held_cnt)) n = int'(held_cnt);
      if (n == 0) begin
        // empty buffer or zero request: one zero result
        r.out_byte       = '0;
        r.last           = 1'b1;
        r.granted_length = '0;
        r.fill_after     = held_cnt;
        expected_bytes_q.push_back(r);
        due_cnt++;
      end else begin
        held_cnt = held_cnt - CAP_W'(n);
        for (int k = 0; k < n; k++) begin
          r.out_byte       = mem_copy[head_ptr];
          r.last           = (k == n - 1);
          r.granted_length = LEN_W'(n);
          r.fill_after     = held_cnt;
          expected_bytes_q.push_back(r);
          due_cnt++;
          head_ptr = next_slot(head_ptr, slots);
        end
      end
    end
  endtask

  // a capacity write empties the ring, stored bytes stay
  task automatic model_capacity_write(logic [CAP_W-1:0] c);
    cap_setting = c;
    head_ptr    = '0;
    tail_ptr    = '0;
    held_cnt    = '0;
  endtask

  task automatic log_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // plan builders
  task automatic plan_write(logic [BYTE_W-1:0] b);
    plan_entry_t e;
    e.kind                = ACT_ITEM;
    e.item.op             = OP_WRITE;
    e.item.data_byte      = b;
    e.item.read_length    = LEN_W'($urandom_range(0, 127));  // ignored on a write
    e.cap                 = '0;
    op_plan_q.push_back(e);
    plan_count++;
    if (plan_fill < plan_slots) plan_fill++;
  endtask

  task automatic plan_read(int len);
    plan_entry_t e;
    int          n;
    e.kind             = ACT_ITEM;
    e.item.op          = OP_READ;
    e.item.data_byte   = BYTE_W'($urandom);                  // ignored on a read
    e.item.read_length = LEN_W'(len);
    e.cap              = '0;
    op_plan_q.push_back(e);
    plan_count++;
    n = (len > MAX_BURST) ? MAX_BURST : len;
    if (n > plan_fill) n = plan_fill;
    plan_fill -= n;
  endtask

  task automatic plan_capacity(logic [CAP_W-1:0] c);
    plan_entry_t e;
    e.kind = ACT_CAPACITY;
    e.item = '0;
    e.cap  = c;
    op_plan_q.push_back(e);
    plan_fill  = 0;
    plan_slots = slots_for(c);
  endtask

  task automatic plan_drain();
    plan_entry_t e;
    e.kind = ACT_DRAIN;
    e.item = '0;
    e.cap  = '0;
    op_plan_q.push_back(e);
  endtask

  // driver: plays the plan, predicts at each accepted transfer
  int gap_left;
  int settle_cnt;
  int feed_pct;

  always @(posedge clk) begin : drive_proc
    logic             nxt_valid;
    logic             nxt_cfg_valid;
    in_item_t         nxt_data;
    logic [CAP_W-1:0] nxt_cfg_data;
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_data     <= '0;
      cfg_valid   <= 1'b0;
      cfg_data    <= '0;
      calm        <= 1'b0;
      cap_setting = CAP_RESET;
      head_ptr    = '0;
      tail_ptr    = '0;
      held_cnt    = '0;
      due_cnt     = 0;
      item_cnt    = 0;
      cap_cnt     = 0;
      gap_left    = 0;
      settle_cnt  = 0;
      feed_pct    = 25;
    end else begin
      nxt_valid     = in_valid;
      nxt_data      = in_data;
      nxt_cfg_valid = cfg_valid;
      nxt_cfg_data  = cfg_data;
      // item transfer
      if (in_valid && !in_stall) begin
        model_buffer_op(in_data);
        item_cnt++;
        nxt_valid = 1'b0;
      end
      // capacity transfer
      if (cfg_valid && cfg_ready) begin
        model_capacity_write(cfg_data);
        cap_cnt++;
        nxt_cfg_valid = 1'b0;
      end
      // pick the next plan entry once nothing is on offer
      if (!nxt_valid && !nxt_cfg_valid && op_plan_q.size() != 0) begin
        case (op_plan_q[0].kind)
          ACT_ITEM: begin
            if (gap_left > 0) begin
              gap_left--;
            end else if (!calm && $urandom_range(99) < feed_pct) begin
              // idle this cycle, then for a random gap held in gap_left
              gap_left = $urandom_range(0, 8);
            end else begin
              nxt_valid = 1'b1;
              nxt_data  = op_plan_q[0].item;
              void'(op_plan_q.pop_front());
              if ($urandom_range(31) == 0) feed_pct = pick_pct();
            end
          end
          ACT_CAPACITY: begin
            // only when idle: all results in, then SETTLE_CYCLES quiet cycles for a late write
            if (got_cnt >= due_cnt) begin
              if (settle_cnt < SETTLE_CYCLES) begin
                settle_cnt++;
              end else begin
                settle_cnt    = 0;
                nxt_cfg_valid = 1'b1;
                nxt_cfg_data  = op_plan_q[0].cap;
                void'(op_plan_q.pop_front());
              end
            end else begin
              settle_cnt = 0;
            end
          end
          default: begin
            // sender holds off until every predicted result is back
            if (got_cnt >= due_cnt) void'(op_plan_q.pop_front());
          end
        endcase
      end
      calm      <= (op_plan_q.size() < TAIL_ITEMS);
      in_valid  <= nxt_valid;
      in_data   <= nxt_data;
      cfg_valid <= nxt_cfg_valid;
      cfg_data  <= nxt_cfg_data;
    end
  end

  // monitor: checks each result transfer, stalls in random bursts
  int stall_left;
  int stall_pct;

  always @(posedge clk) begin : watch_proc
    out_item_t want;
    logic      nxt_stall;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      got_cnt    <= 0;
      stall_left = 0;
      stall_pct  = 25;
    end else begin
      if (out_valid && !out_stall) begin
        got_cnt <= got_cnt + 1;
        if (expected_bytes_q.size() == 0) begin
          log_mismatch($sformatf("result with none expected: byte %02h last %0d granted %0d fill %0d",
                                 out_data.out_byte, out_data.last,
                                 out_data.granted_length, out_data.fill_after));
        end else begin
          want = expected_bytes_q.pop_front();
          if (out_data !== want)
            log_mismatch($sformatf(
              "exp/act byte %02h/%02h last %0d/%0d granted %0d/%0d fill %0d/%0d",
              want.out_byte, out_data.out_byte, want.last, out_data.last,
              want.granted_length, out_data.granted_length,
              want.fill_after, out_data.fill_after));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (!calm && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(0, 8);
        nxt_stall  = 1'b1;
      end else begin
        nxt_stall = 1'b0;
        if ($urandom_range(63) == 0) stall_pct = pick_pct();
      end
      out_stall <= nxt_stall;
    end
  end

  // plan, then wait for the end
  initial begin : main_proc
    int steps;
    int r;
    int top;
    logic [CAP_W-1:0] c;
    plan_fill  = 0;
    plan_slots = DEPTH;
    plan_count = 0;

    // directed: reset capacity, reads on an empty ring
    plan_read(5);
    plan_read(0);
    // byte extremes, zero request on a non-empty ring, request over the burst limit
    plan_write(8'h00);
    plan_write(8'hFF);
    plan_write(8'hA5);
    plan_read(0);
    plan_read(127);
    // zero capacity acts as a single slot, second write overwrites
    plan_capacity('0);
    plan_write(8'h11);
    plan_write(8'h22);
    plan_read(64);
    // capacity past the store acts as the whole store
    plan_capacity(13'h1FFF);
    plan_write(8'h5A);
    plan_write(8'hC3);
    plan_write(8'h3C);
    plan_read(2);
    plan_drain();
    plan_read(1);
    // small ring overfilled, then a capacity write leaves it empty
    plan_capacity(13'd3);
    repeat (5) plan_write(BYTE_W'($urandom));
    plan_read(100);
    repeat (2) plan_write(BYTE_W'($urandom));
    plan_capacity(13'd5);
    plan_read(10);

    // one full burst from a ring past 64 bytes
    plan_capacity(CAP_W'($urandom_range(64, 80)));
    repeat ($urandom_range(64, 72)) plan_write(BYTE_W'($urandom));
    plan_read(64);
    plan_read(127);

    // random phases: capacity setting, then mixed write bursts and reads
    while (plan_count < RANDOM_ITEMS) begin
      r = $urandom_range(19);
      case (r)
        0: c = '0;
        1: c = 13'd1;
        2: c = CAP_MAX;
        3: c = 13'h1FFF;
        4: c = CAP_W'($urandom_range(4097, 8191));
        5: c = CAP_W'($urandom);
        default: c = CAP_W'($urandom_range(2, 40));
      endcase
      plan_capacity(c);
      steps = $urandom_range(8, 25);
      for (int s = 0; s < steps && plan_count < RANDOM_ITEMS; s++) begin
        if ($urandom_range(99) < 55) begin
          repeat ($urandom_range(1, 8)) plan_write(BYTE_W'($urandom));
        end else begin
          r   = $urandom_range(99);
          top = ((plan_fill > MAX_BURST) ? MAX_BURST : plan_fill) + 2;
          if (r < 65) plan_read($urandom_range(1, top));
          else if (r < 80) plan_read($urandom_range(0, 127));
          else if (r < 90) plan_read(0);
          else plan_read(MAX_BURST);
        end
        if ($urandom_range(29) == 0) plan_drain();
      end
    end
    plan_drain();

    // all stimulus taken and every result back, then watch for stragglers
    do @(negedge clk);
    while (op_plan_q.size() != 0 || in_valid || cfg_valid || expected_bytes_q.size() != 0);
    repeat (END_CYCLES) @(negedge clk);
    if (expected_bytes_q.size() != 0)
      log_mismatch($sformatf("%0d expected results never arrived", expected_bytes_q.size()));

    $display("covered %0d item transfers, %0d result transfers, %0d capacity writes",
             item_cnt, got_cnt, cap_cnt);
    $display("capacities from zero to all ones, overwrite when full, empty and clamped reads");
    if (err_cnt == 0) begin
      $display("overwrite_ring_byte_buffer test passed");
    end else begin
      $display("%0d mismatches in total", err_cnt);
      $display("overwrite_ring_byte_buffer test failed");
    end
    $finish;
  end

  // hang guard, far past the slowest legal run
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", expected_bytes_q.size());
    $display("overwrite_ring_byte_buffer test failed");
    $finish;
  end

endmodule
